// ----- sv/lgs_pkg.sv -----
// ----------------------------------------------------------------------------
// lgs_pkg
// Shared types and codes for the bounded life-grid generation step block.
// ----------------------------------------------------------------------------
package lgs_pkg;

	localparam logic [1:0] OP_WRITE = 2'd0;
	localparam logic [1:0] OP_RUN   = 2'd1;
	localparam logic [1:0] OP_READ  = 2'd2;

	localparam int unsigned COORD_W = 5;
	localparam int unsigned GEN_W   = 16;

	typedef struct packed {
		logic [1:0]         op;
		logic [COORD_W-1:0] col;
		logic [COORD_W-1:0] row;
		logic               alive_in;
		logic [GEN_W-1:0]   gens_to_run;
	} lgs_in_t;

	typedef struct packed {
		logic             alive_out;
		logic [GEN_W-1:0] generation;
	} lgs_out_t;

	// Control broadcast from the sequencer to every row cell
	typedef struct packed {
		logic               advance;
		logic               wr_en;
		logic [COORD_W-1:0] wr_row;
		logic [COORD_W-1:0] wr_col;
		logic               wr_val;
	} lgs_cell_ctl_t;

endpackage

// ----- sv/lgs_row_cell.sv -----
// ----------------------------------------------------------------------------
// lgs_row_cell
// Holds one grid row; takes the rows above and below from its neighbors and
// steps the row by one generation (B3/S23) when told to advance.
// ----------------------------------------------------------------------------
module lgs_row_cell
	import lgs_pkg::*;
#(
	parameter int GRID_SIZE = 32,
	parameter int ROW_IDX   = 0
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  lgs_cell_ctl_t        ctl,
	input  logic [GRID_SIZE-1:0] up_row,
	input  logic [GRID_SIZE-1:0] dn_row,
	output logic [GRID_SIZE-1:0] cur_row
);

	logic [GRID_SIZE-1:0] row_q;
	logic [GRID_SIZE-1:0] next_row;
	logic [GRID_SIZE-1:0] wr_mask;
	logic                 row_hit;

	assign cur_row = row_q;
	assign row_hit = (32'(ctl.wr_row) == 32'(ROW_IDX));
	assign wr_mask = GRID_SIZE'(1) << ctl.wr_col;

	// Per-column neighbor count: s0/s1 count bits, s2 sticks at four or more
	always_comb begin
		logic [GRID_SIZE-1:0] nb [8];
		logic [GRID_SIZE-1:0] s0, s1, s2, c0, c1;
		nb[0] = up_row << 1;
		nb[1] = up_row;
		nb[2] = up_row >> 1;
		nb[3] = row_q << 1;
		nb[4] = row_q >> 1;
		nb[5] = dn_row << 1;
		nb[6] = dn_row;
		nb[7] = dn_row >> 1;
		s0 = '0;
		s1 = '0;
		s2 = '0;
		for (int i = 0; i < 8; i++) begin
			c0 = s0 & nb[i];
			s0 = s0 ^ nb[i];
			c1 = s1 & c0;
			s1 = s1 ^ c0;
			s2 = s2 | c1;
		end
		next_row = (s0 & s1 & ~s2) | (row_q & ~s0 & s1 & ~s2);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
		end else if (ctl.advance) begin
			row_q <= next_row;
		end else if (ctl.wr_en && row_hit) begin
			if (ctl.wr_val) begin
				row_q <= row_q | wr_mask;
			end else begin
				row_q <= row_q & ~wr_mask;
			end
		end
	end

endmodule

// ----- sv/life_grid_generation_step.sv -----
// ----------------------------------------------------------------------------
// life_grid_generation_step
// Bounded Game of Life grid with cell write, cell read and multi-generation run.
// ----------------------------------------------------------------------------
// The grid is a chain of GRID_SIZE row cells, each holding one row and
// trading rows with its upper and lower neighbor every cycle, so the whole
// grid advances one generation per clock while a run is in progress. A run
// item of N generations (N > 0) keeps the input closed until the grid has
// advanced N generations, and its result appears in the cycle after the
// last generation. Every result passes through one output register, and a
// new item can be taken in the same cycle that the previous result is
// transferred. Cells outside the grid read as dead and writes there are
// dropped; the generation count saturates at 65535 while the grid keeps
// advancing.
module life_grid_generation_step
	import lgs_pkg::*;
#(
	parameter int GRID_SIZE = 32
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  lgs_in_t  in_data,
	output logic     out_valid,
	input  logic     out_ready,
	output lgs_out_t out_data
);

	localparam int IDX_W = (GRID_SIZE > 1) ? $clog2(GRID_SIZE) : 1;

	typedef enum logic {
		ST_IDLE,
		ST_RUN
	} state_t;

	state_t               state_q;
	logic [GEN_W-1:0]     remain_q;
	logic [GEN_W-1:0]     gen_q;
	logic                 out_valid_q;
	lgs_out_t             out_q;

	lgs_cell_ctl_t        ctl;
	logic [GRID_SIZE-1:0] rows [GRID_SIZE];
	logic                 accept;
	logic                 on_grid;
	logic [GEN_W:0]       gen_sum;
	logic [GEN_W-1:0]     gen_next;
	logic [IDX_W-1:0]     rd_row;
	logic [IDX_W-1:0]     rd_col;
	logic                 rd_bit;

	assign in_ready  = (state_q == ST_IDLE) && (!out_valid_q || out_ready);
	assign accept    = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	assign on_grid = (32'(in_data.col) < 32'(GRID_SIZE)) &&
		(32'(in_data.row) < 32'(GRID_SIZE));

	assign gen_sum  = {1'b0, gen_q} + {1'b0, in_data.gens_to_run};
	assign gen_next = gen_sum[GEN_W] ? {GEN_W{1'b1}} : gen_sum[GEN_W-1:0];

	assign rd_row = IDX_W'(in_data.row);
	assign rd_col = IDX_W'(in_data.col);
	assign rd_bit = on_grid && rows[rd_row][rd_col];

	always_comb begin
		ctl.advance = (state_q == ST_RUN);
		ctl.wr_en   = accept && (in_data.op == OP_WRITE) && on_grid;
		ctl.wr_row  = in_data.row;
		ctl.wr_col  = in_data.col;
		ctl.wr_val  = in_data.alive_in;
	end

	for (genvar r = 0; r < GRID_SIZE; r++) begin : g_row
		logic [GRID_SIZE-1:0] up_row;
		logic [GRID_SIZE-1:0] dn_row;

		if (r == 0) begin : g_top
			assign up_row = '0;
		end else begin : g_up
			assign up_row = rows[r-1];
		end

		if (r == GRID_SIZE - 1) begin : g_bot
			assign dn_row = '0;
		end else begin : g_dn
			assign dn_row = rows[r+1];
		end

		lgs_row_cell #(
			.GRID_SIZE(GRID_SIZE),
			.ROW_IDX  (r)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl    (ctl),
			.up_row (up_row),
			.dn_row (dn_row),
			.cur_row(rows[r])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			remain_q    <= '0;
			gen_q       <= '0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (in_data.op == OP_RUN) begin
							gen_q <= gen_next;
							if (in_data.gens_to_run != '0) begin
								remain_q <= in_data.gens_to_run;
								state_q  <= ST_RUN;
							end else begin
								out_valid_q <= 1'b1;
								out_q       <= '{alive_out: 1'b0, generation: gen_q};
							end
						end else begin
							out_valid_q <= 1'b1;
							out_q.alive_out  <= (in_data.op == OP_READ) && rd_bit;
							out_q.generation <= gen_q;
						end
					end
				end
				ST_RUN: begin
					remain_q <= remain_q - GEN_W'(1);
					// last generation: release the result
					if (remain_q == GEN_W'(1)) begin
						state_q     <= ST_IDLE;
						out_valid_q <= 1'b1;
						out_q       <= '{alive_out: 1'b0, generation: gen_q};
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ----- sv/lgs_checker.sv -----
// ----------------------------------------------------------------------------
// lgs_checker
// Port-level checks for the life-grid generation step block.
// ----------------------------------------------------------------------------
module lgs_checker
	import lgs_pkg::*;
(
	input logic     clk,
	input logic     arst_n,
	input logic     in_valid,
	input logic     in_ready,
	input lgs_in_t  in_data,
	input logic     out_valid,
	input logic     out_ready,
	input lgs_out_t out_data
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	// no new item while a result waits untaken
	a_no_accept_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("input open while output is blocked");

	// a write transfer returns a dead cell in the next cycle
	a_write_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_data.op == OP_WRITE |=>
		out_valid && !out_data.alive_out)
		else $error("write result missing or nonzero");

	// a nonzero run closes the input for at least the next cycle
	a_run_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_data.op == OP_RUN && in_data.gens_to_run != '0 |=>
		!in_ready && !out_valid)
		else $error("run did not hold the input closed");

endmodule

bind life_grid_generation_step lgs_checker u_lgs_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (in_valid),
	.in_ready (in_ready),
	.in_data  (in_data),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.out_data (out_data)
);

// ----- tb/life_grid_generation_step_tb.sv -----
// ----------------------------------------------------------------------------
// life_grid_generation_step_tb
// Self-checking bench for the bounded life grid: writes, reads and runs go
// through valid/ready into the block, a shadow grid advances under B3/S23,
// and every reply is checked field by field against the shadow grid's answer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module life_grid_generation_step_tb;
	import lgs_pkg::*;

	localparam int GRID_SIZE = 32;
	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam logic [GEN_W-1:0] GEN_LIMIT = '1;
	localparam int unsigned RANDOM_UNTIL = 1930;

	typedef struct {
		lgs_in_t cmd;
		bit      settle;
	} queued_cmd_t;

	logic     clk = 1'b0;
	logic     arst_n = 1'b0;
	logic     in_valid = 1'b0;
	logic     in_ready;
	lgs_in_t  in_data = '0;
	logic     out_valid;
	logic     out_ready = 1'b0;
	lgs_out_t out_data;

	queued_cmd_t cmd_backlog[$];
	lgs_out_t    reply_backlog[$];

	logic [GRID_SIZE-1:0] shadow_grid [GRID_SIZE];
	logic [GEN_W-1:0]     shadow_gen = '0;

	logic        in_xfer = 1'b0;
	int unsigned cmds_taken = 0;
	int unsigned replies_seen = 0;
	int unsigned error_count = 0;
	int unsigned hold_left = 0;
	bit          hold_done = 1'b0;

	life_grid_generation_step #(
		.GRID_SIZE(GRID_SIZE)
	) uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

	always #5 clk = ~clk;

	initial begin
		for (int r = 0; r < GRID_SIZE; r++)
			shadow_grid[r] = '0;
	end

	// Next state of one row from its own and its neighbor rows; cells past the
	// edges count as dead, so shifted-out bits are simply dropped.
	function automatic logic [GRID_SIZE-1:0] evolve_row(input logic [GRID_SIZE-1:0] up,
			input logic [GRID_SIZE-1:0] cur, input logic [GRID_SIZE-1:0] dn);
		logic [GRID_SIZE-1:0] nb [8];
		logic [GRID_SIZE-1:0] ones, twos, many, c1, c2;
		nb[0] = up << 1;
		nb[1] = up;
		nb[2] = up >> 1;
		nb[3] = cur << 1;
		nb[4] = cur >> 1;
		nb[5] = dn << 1;
		nb[6] = dn;
		nb[7] = dn >> 1;
		ones = '0;
		twos = '0;
		many = '0;
		for (int i = 0; i < 8; i++) begin
			c1 = ones & nb[i];
			ones = ones ^ nb[i];
			c2 = twos & c1;
			twos = twos ^ c1;
			many = many | c2;
		end
		// born on three, survive on two or three
		return ~many & twos & (ones | cur);
	endfunction

	task automatic step_grid();
		logic [GRID_SIZE-1:0] nxt [GRID_SIZE];
		logic [GRID_SIZE-1:0] up, dn;
		for (int r = 0; r < GRID_SIZE; r++) begin
			up = (r > 0) ? shadow_grid[r-1] : '0;
			dn = (r < GRID_SIZE - 1) ? shadow_grid[r+1] : '0;
			nxt[r] = evolve_row(up, shadow_grid[r], dn);
		end
		for (int r = 0; r < GRID_SIZE; r++)
			shadow_grid[r] = nxt[r];
	endtask

	task automatic apply_command(input lgs_in_t c);
		lgs_out_t    reply;
		int unsigned total;
		bit          on_grid;
		on_grid = (c.col < GRID_SIZE) && (c.row < GRID_SIZE);
		reply.alive_out = 1'b0;
		case (c.op)
			OP_WRITE: begin
				if (on_grid)
					shadow_grid[c.row][c.col] = c.alive_in;
			end
			OP_RUN: begin
				repeat (c.gens_to_run) step_grid();
				total = shadow_gen + c.gens_to_run;
				shadow_gen = (total > GEN_LIMIT) ? GEN_LIMIT : total[GEN_W-1:0];
			end
			OP_READ: begin
				if (on_grid)
					reply.alive_out = shadow_grid[c.row][c.col];
			end
			default: begin
			end
		endcase
		reply.generation = shadow_gen;
		reply_backlog.push_back(reply);
	endtask

	function automatic lgs_in_t random_cmd(input logic [1:0] op);
		lgs_in_t c;
		c.op = op;
		c.col = COORD_W'($urandom_range(0, 31));
		c.row = COORD_W'($urandom_range(0, 31));
		c.alive_in = 1'($urandom_range(0, 1));
		c.gens_to_run = GEN_W'($urandom_range(0, 16'hFFFF));
		return c;
	endfunction

	task automatic queue_cmd(input lgs_in_t c, input bit settle);
		queued_cmd_t q;
		q.cmd = c;
		q.settle = settle;
		cmd_backlog.push_back(q);
	endtask

	task automatic queue_fixed(input logic [1:0] op, input int col, input int row,
			input bit alive, input int gens, input bit settle);
		lgs_in_t c;
		c.op = op;
		c.col = COORD_W'(col);
		c.row = COORD_W'(row);
		c.alive_in = alive;
		c.gens_to_run = GEN_W'(gens);
		queue_cmd(c, settle);
	endtask

	function automatic int clamp_coord(input int v);
		return (v < 0) ? 0 : (v > GRID_SIZE - 1) ? GRID_SIZE - 1 : v;
	endfunction

	// Driver: offer the next command at the falling edge once the last one
	// has been transferred.
	always @(negedge clk) begin : driver
		queued_cmd_t nxt;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || in_xfer) begin
			if (cmd_backlog.size() == 0) begin
				in_valid <= 1'b0;
			end else if (!(cmds_taken >= 400 && cmds_taken < 700) &&
					$urandom_range(0, 99) < 26) begin
				in_valid <= 1'b0;
			end else if (cmd_backlog[0].settle && reply_backlog.size() != 0) begin
				// hold until the block has drained
				in_valid <= 1'b0;
			end else begin
				nxt = cmd_backlog.pop_front();
				in_data <= nxt.cmd;
				in_valid <= 1'b1;
			end
		end
	end

	// Receiver side ready, with one long hold-off to back the block up
	always @(negedge clk) begin : reply_sink
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left = hold_left - 1;
			out_ready <= 1'b0;
		end else if (!hold_done && replies_seen >= 1000) begin
			hold_done = 1'b1;
			hold_left = 300;
			out_ready <= 1'b0;
		end else if (replies_seen >= 400 && replies_seen < 700) begin
			out_ready <= 1'b1;
		end else begin
			out_ready <= ($urandom_range(0, 99) >= 26);
		end
	end

	always @(posedge clk) begin : monitor
		lgs_out_t want;
		if (!arst_n) begin
			in_xfer <= 1'b0;
		end else begin
			in_xfer <= in_valid && in_ready;
			if (out_valid && out_ready) begin
				replies_seen++;
				if (reply_backlog.size() == 0) begin
					error_count++;
					$display("%0t: unexpected reply: expected none, actual alive %0d gen %0d",
						$time, out_data.alive_out, out_data.generation);
				end else begin
					want = reply_backlog.pop_front();
					if (out_data.alive_out !== want.alive_out) begin
						error_count++;
						$display("%0t: alive_out mismatch: expected %0d, actual %0d",
							$time, want.alive_out, out_data.alive_out);
					end
					if (out_data.generation !== want.generation) begin
						error_count++;
						$display("%0t: generation mismatch: expected %0d, actual %0d",
							$time, want.generation, out_data.generation);
					end
				end
			end
			if (in_valid && in_ready) begin
				cmds_taken++;
				apply_command(in_data);
			end
		end
	end

	initial begin : main
		lgs_in_t c;
		int      wc, wr, n, rounds, pick;
		bit      settle;

		// Directed: empty grid, unused code, zero run, corners, edge blinker
		queue_fixed(OP_READ, 0, 0, 1'b1, 16'hFFFF, 1'b0);
		queue_fixed(OP_UNUSED, 31, 31, 1'b1, 16'hFFFF, 1'b0);
		queue_fixed(OP_UNUSED, 0, 0, 1'b0, 0, 1'b0);
		queue_fixed(OP_RUN, 31, 31, 1'b1, 0, 1'b0);
		queue_fixed(OP_WRITE, 0, 0, 1'b1, 0, 1'b0);
		queue_fixed(OP_WRITE, 31, 0, 1'b1, 16'hFFFF, 1'b0);
		queue_fixed(OP_WRITE, 0, 31, 1'b1, 0, 1'b0);
		queue_fixed(OP_WRITE, 31, 31, 1'b1, 0, 1'b0);
		queue_fixed(OP_READ, 31, 31, 1'b0, 0, 1'b0);
		queue_fixed(OP_WRITE, 0, 0, 1'b0, 0, 1'b0);
		queue_fixed(OP_READ, 0, 0, 1'b1, 0, 1'b0);
		queue_fixed(OP_WRITE, 10, 0, 1'b1, 0, 1'b0);
		queue_fixed(OP_WRITE, 11, 0, 1'b1, 0, 1'b0);
		queue_fixed(OP_WRITE, 12, 0, 1'b1, 0, 1'b0);
		queue_fixed(OP_RUN, 0, 0, 1'b0, 1, 1'b0);
		queue_fixed(OP_READ, 11, 0, 1'b0, 0, 1'b0);
		queue_fixed(OP_READ, 11, 1, 1'b0, 0, 1'b0);
		queue_fixed(OP_READ, 10, 0, 1'b0, 0, 1'b0);
		queue_fixed(OP_READ, 31, 31, 1'b0, 0, 1'b0);
		queue_fixed(OP_RUN, 0, 0, 1'b0, 2, 1'b0);
		queue_fixed(OP_READ, 11, 0, 1'b0, 0, 1'b0);
		queue_fixed(OP_READ, 12, 0, 1'b0, 0, 1'b0);

		// Random: seed a small window densely, then let it evolve and probe it
		while (cmd_backlog.size() < RANDOM_UNTIL) begin
			wc = $urandom_range(0, GRID_SIZE - 6);
			wr = $urandom_range(0, GRID_SIZE - 6);
			settle = ($urandom_range(0, 7) == 0);
			n = $urandom_range(4, 20);
			for (int k = 0; k < n; k++) begin
				c = random_cmd(OP_WRITE);
				if ($urandom_range(0, 9) != 0) begin
					c.col = COORD_W'(wc + $urandom_range(0, 5));
					c.row = COORD_W'(wr + $urandom_range(0, 5));
					c.alive_in = ($urandom_range(0, 99) < 75);
				end
				queue_cmd(c, settle && k == 0);
			end
			rounds = $urandom_range(1, 3);
			for (int j = 0; j < rounds; j++) begin
				c = random_cmd(OP_RUN);
				pick = $urandom_range(0, 99);
				c.gens_to_run = GEN_W'((pick < 15) ? 0 :
					(pick < 85) ? $urandom_range(1, 8) : $urandom_range(9, 200));
				queue_cmd(c, 1'b0);
				n = $urandom_range(3, 12);
				for (int k = 0; k < n; k++) begin
					c = random_cmd(OP_READ);
					if ($urandom_range(0, 4) != 0) begin
						c.col = COORD_W'(clamp_coord(wc + $urandom_range(0, 7) - 1));
						c.row = COORD_W'(clamp_coord(wr + $urandom_range(0, 7) - 1));
					end
					queue_cmd(c, 1'b0);
				end
				if ($urandom_range(0, 9) == 0)
					queue_cmd(random_cmd(OP_UNUSED), 1'b0);
			end
		end

		// Long runs: push the counter into saturation and keep advancing
		queue_fixed(OP_WRITE, 20, 20, 1'b1, 0, 1'b1);
		queue_fixed(OP_WRITE, 21, 20, 1'b1, 0, 1'b0);
		queue_fixed(OP_WRITE, 20, 21, 1'b1, 0, 1'b0);
		queue_fixed(OP_WRITE, 21, 21, 1'b1, 0, 1'b0);
		queue_fixed(OP_RUN, 0, 0, 1'b0, 16'h8000, 1'b0);
		queue_fixed(OP_READ, 20, 20, 1'b0, 0, 1'b0);
		queue_fixed(OP_RUN, 31, 31, 1'b1, 16'hFFFF, 1'b0);
		queue_fixed(OP_READ, 21, 21, 1'b0, 0, 1'b0);
		queue_fixed(OP_WRITE, 5, 15, 1'b1, 0, 1'b0);
		queue_fixed(OP_WRITE, 6, 15, 1'b1, 0, 1'b0);
		queue_fixed(OP_WRITE, 7, 15, 1'b1, 0, 1'b0);
		queue_fixed(OP_RUN, 0, 0, 1'b0, 3, 1'b0);
		queue_fixed(OP_READ, 6, 14, 1'b0, 0, 1'b0);
		queue_fixed(OP_READ, 6, 16, 1'b0, 0, 1'b0);
		queue_fixed(OP_READ, 5, 15, 1'b0, 0, 1'b0);
		queue_fixed(OP_RUN, 0, 0, 1'b0, 0, 1'b0);
		queue_fixed(OP_READ, 6, 15, 1'b0, 0, 1'b0);

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		do
			@(negedge clk);
		while (cmd_backlog.size() != 0 || in_valid || reply_backlog.size() != 0);
		repeat (20) @(posedge clk);

		if (error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin : watchdog
		#20_000_000;
		$display("%0t: timeout", $time);
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// ----- filelist.f -----
sv/lgs_pkg.sv
sv/lgs_row_cell.sv
sv/life_grid_generation_step.sv
sv/lgs_checker.sv
tb/life_grid_generation_step_tb.sv
